// ===== rtl/core/posit64_to_int64_assert.svh =====
// Assertion macros for the posit64_to_int64 checker.
// Both macros sample on clk and are off while rst_n is low.
`ifndef POSIT64_TO_INT64_ASSERT_SVH
`define POSIT64_TO_INT64_ASSERT_SVH

// Same-cycle implication.
`define P64I_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define P64I_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/p64i_pkg.sv =====
// Shared constants and stage payload types for the posit64 to int64 converter.
// No dependencies.
package p64i_pkg;

    localparam logic [63:0] NAR_PATTERN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_MAX_BITS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_MIN_BITS = 64'h8000_0000_0000_0000;

    // Register stages from input to output.
    localparam int unsigned P64I_DEPTH = 5;

    // Regime run length found, regime not yet stripped.
    typedef struct packed {
        logic        neg;
        logic        special;
        logic        lead;
        logic [5:0]  run_len;
        logic [63:0] body;
    } p64i_regime_t;

    // Scale and left-justified fraction.
    typedef struct packed {
        logic              neg;
        logic              special;
        logic signed [9:0] scale;
        logic [63:0]       frac;
    } p64i_fields_t;

endpackage

// ===== rtl/core/p64i_posit_if.sv =====
// Request channel carrying one posit64 pattern.
// Depends on nothing.
interface p64i_posit_if;
    logic        valid;
    logic        ready;
    logic [63:0] posit_bits;

    modport source (output valid, output posit_bits, input ready);
    modport sink (input valid, input posit_bits, output ready);
endinterface

// ===== rtl/core/p64i_int_if.sv =====
// Request channel carrying one signed 64-bit integer.
// Depends on nothing.
interface p64i_int_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] int_value;

    modport source (output valid, output int_value, input ready);
    modport sink (input valid, input int_value, output ready);
endinterface

// ===== rtl/core/p64i_front.sv =====
// Stages 1 and 2: special-case detect, two's complement of negative posits,
// and regime run-length count. Depends on p64i_pkg.
module p64i_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           posit_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output p64i_pkg::p64i_regime_t out_data
);

    typedef struct packed {
        logic        neg;
        logic        special;
        logic [63:0] body;
    } s1_t;

    // Leading zero count: per-byte counts, then pick the top nonzero byte.
    function automatic logic [5:0] lzc64(input logic [63:0] v);
        logic [2:0] byte_cnt [8];
        logic [7:0] nz;
        logic [5:0] res;
        res = 6'd0;
        for (int g = 0; g < 8; g++)
        begin
            nz[g] = |v[g*8 +: 8];
            byte_cnt[g] = 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                if (v[g*8 + i])
                begin
                    byte_cnt[g] = 3'(7 - i);
                end
            end
        end
        for (int g = 0; g < 8; g++)
        begin
            if (nz[g])
            begin
                res = {3'(7 - g), byte_cnt[g]};
            end
        end
        return res;
    endfunction

    logic        s1_valid_reg;
    s1_t         s1_data_reg;
    s1_t         s1_data_next;
    logic        s2_valid_reg;
    p64i_pkg::p64i_regime_t s2_data_reg;
    p64i_pkg::p64i_regime_t s2_data_next;
    logic        s1_ready;
    logic        s2_ready;
    logic [63:0] mag;
    logic [63:0] run_src;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        mag = posit_bits[63] ? (64'd0 - posit_bits) : posit_bits;
        s1_data_next.neg = posit_bits[63];
        s1_data_next.special = (posit_bits == 64'd0) ||
                               (posit_bits == p64i_pkg::NAR_PATTERN);
        // drop the sign bit
        s1_data_next.body = {mag[62:0], 1'b0};
    end

    always_comb
    begin
        run_src = s1_data_reg.body[63] ? ~s1_data_reg.body : s1_data_reg.body;
        s2_data_next.neg = s1_data_reg.neg;
        s2_data_next.special = s1_data_reg.special;
        s2_data_next.lead = s1_data_reg.body[63];
        s2_data_next.run_len = lzc64(run_src);
        s2_data_next.body = s1_data_reg.body;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_data_reg <= s1_data_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data = s2_data_reg;

endmodule

// ===== rtl/core/p64i_align.sv =====
// Stage 3: strip the regime, form the binary scale and the fraction.
// Depends on p64i_pkg.
module p64i_align (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  p64i_pkg::p64i_regime_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output p64i_pkg::p64i_fields_t out_data
);

    logic                   s3_valid_reg;
    p64i_pkg::p64i_fields_t s3_data_reg;
    p64i_pkg::p64i_fields_t s3_data_next;
    logic                   s3_ready;
    logic [6:0]             shamt;
    logic [63:0]            shifted;
    logic signed [9:0]      regime_k;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign in_ready = s3_ready;

    always_comb
    begin
        // skip the run and its terminating bit; a shift of 64 clears the word
        shamt = {1'b0, in_data.run_len} + 7'd1;
        shifted = in_data.body << shamt;
        regime_k = in_data.lead ? ($signed({4'b0, in_data.run_len}) - 10'sd1)
                                : -$signed({4'b0, in_data.run_len});
        s3_data_next.neg = in_data.neg;
        s3_data_next.special = in_data.special;
        s3_data_next.scale = (regime_k <<< 2) + $signed({8'b0, shifted[63:62]});
        s3_data_next.frac = {shifted[61:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data = s3_data_reg;

endmodule

// ===== rtl/core/p64i_round.sv =====
// Stages 4 and 5: integer part with round and sticky bits, then round-to-even
// increment, saturation and sign restore. Depends on p64i_pkg.
module p64i_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  p64i_pkg::p64i_fields_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [63:0]     int_value
);

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic        sat;
        logic        inc;
        logic [63:0] ip;
    } s4_t;

    logic        s4_valid_reg;
    s4_t         s4_data_reg;
    s4_t         s4_data_next;
    logic        s5_valid_reg;
    logic [63:0] int_value_reg;
    logic [63:0] int_value_next;
    logic        s4_ready;
    logic        s5_ready;
    logic        half;
    logic [5:0]  sc6;
    logic [6:0]  rshamt;
    logic [64:0] wide;
    logic [63:0] rem;
    logic        rnd;
    logic        sticky;
    logic        carry_out;
    logic [63:0] sum;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    always_comb
    begin
        half = (in_data.scale == -10'sd1);
        sc6 = in_data.scale[5:0];
        rshamt = 7'd64 - {1'b0, sc6};
        // hidden one above the fraction
        wide = {1'b1, in_data.frac} >> rshamt;
        rem = in_data.frac << sc6;
        rnd = half ? 1'b1 : rem[63];
        sticky = half ? (|in_data.frac) : (|rem[62:0]);
        s4_data_next.neg = in_data.neg;
        s4_data_next.zero = in_data.special || (in_data.scale < -10'sd1);
        s4_data_next.sat = (in_data.scale > 10'sd62);
        s4_data_next.ip = half ? 64'd0 : wide[63:0];
        s4_data_next.inc = rnd && (sticky || (!half && wide[0]));
    end

    always_comb
    begin
        carry_out = s4_data_reg.inc && (&s4_data_reg.ip[62:0]);
        // negate as ~ip + 1 - inc to fold the increment into one adder
        sum = (s4_data_reg.ip ^ {64{s4_data_reg.neg}}) +
              {63'd0, s4_data_reg.neg ? !s4_data_reg.inc : s4_data_reg.inc};
        if (s4_data_reg.zero)
        begin
            int_value_next = 64'd0;
        end
        else if (s4_data_reg.sat || carry_out)
        begin
            int_value_next = s4_data_reg.neg ? p64i_pkg::INT_MIN_BITS
                                             : p64i_pkg::INT_MAX_BITS;
        end
        else
        begin
            int_value_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= in_valid;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && in_valid)
        begin
            s4_data_reg <= s4_data_next;
        end
        if (s5_ready && s4_valid_reg)
        begin
            int_value_reg <= int_value_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign int_value = $signed(int_value_reg);

endmodule

// ===== rtl/core/posit64_to_int64.sv =====
// Converts a 64-bit posit (es = 2) to the nearest signed 64-bit integer,
// rounding to nearest with ties to even; NaR and zero give 0, and magnitudes
// that round to 2^63 or more saturate. The block accepts one posit per clock
// while the output is not stalled; the five register stages are negate,
// regime count, regime strip, round shift, and increment/saturate, and a stall
// at the output lets empty stages fill and then holds every stage in place
// without loss. Depends on p64i_pkg, p64i_posit_if, p64i_int_if, p64i_front,
// p64i_align and p64i_round.
module posit64_to_int64 (
    input logic         clk,
    input logic         rst_n,
    p64i_posit_if.sink  posit_in,
    p64i_int_if.source  int_out
);

    logic                   front_valid;
    logic                   front_ready;
    p64i_pkg::p64i_regime_t front_data;
    logic                   align_valid;
    logic                   align_ready;
    p64i_pkg::p64i_fields_t align_data;

    p64i_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (posit_in.valid),
        .in_ready   (posit_in.ready),
        .posit_bits (posit_in.posit_bits),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    p64i_align u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (align_valid),
        .out_ready (align_ready),
        .out_data  (align_data)
    );

    p64i_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (align_valid),
        .in_ready  (align_ready),
        .in_data   (align_data),
        .out_valid (int_out.valid),
        .out_ready (int_out.ready),
        .int_value (int_out.int_value)
    );

endmodule

// ===== rtl/core/p64i_checker.sv =====
// Port-level checker for posit64_to_int64, bound to the top level below.
// Depends on p64i_pkg and posit64_to_int64_assert.svh.
`include "posit64_to_int64_assert.svh"

module p64i_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [63:0] int_value
);

    logic [2:0] flight_reg;
    logic [2:0] flight_next;

    // track requests accepted but not yet delivered
    always_comb
    begin
        flight_next = flight_reg + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= 3'd0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    `P64I_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `P64I_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(int_value), "result changed")
    `P64I_ASSERT_IMP(a_ready_low, !in_ready, out_valid, "input stalled with no result waiting")
    `P64I_ASSERT_IMP(a_no_phantom, out_valid, flight_reg != 3'd0, "result without request")
    `P64I_ASSERT_IMP(a_depth, 1'b1, flight_reg <= 3'(p64i_pkg::P64I_DEPTH), "too many in flight")

endmodule

bind posit64_to_int64 p64i_checker u_p64i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (posit_in.valid),
    .in_ready  (posit_in.ready),
    .out_valid (int_out.valid),
    .out_ready (int_out.ready),
    .int_value (int_out.int_value)
);
